>>> rtl/isct_pkg.sv
// package with types, codes and sizes shared by the slot claim table
`timescale 1ns / 1ps

package isct_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [63:0] FREE_MARK = '1;

  localparam logic [1:0] KIND_ACQUIRE = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_CHECK   = 2'd2;

  localparam logic [2:0] ST_ACQUIRED    = 3'd0;
  localparam logic [2:0] ST_ALREADY     = 3'd1;
  localparam logic [2:0] ST_FULL        = 3'd2;
  localparam logic [2:0] ST_STILL       = 3'd3;
  localparam logic [2:0] ST_NOT_HELD    = 3'd4;
  localparam logic [2:0] ST_RELEASED    = 3'd5;
  localparam logic [2:0] ST_NOT_ENABLED = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] owner_id;
    logic [2:0]  slot;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] slot_index;
  } rsp_t;

  typedef struct packed {
    logic              load;
    logic              rd_en;
    logic              rd_sel_slot;
    logic [SLOT_W-1:0] rd_addr;
    logic              cmp_en;
    logic              commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic need_read;
    logic out_busy;
  } dp_status_t;

endpackage

>>> rtl/id_slot_claim_table.sv
// top level of the slot claim table: controller and datapath
`timescale 1ns / 1ps

// Requests enter on the in channel (kind, owner_id, slot) and each one
// gives exactly one response (status, slot_index) on the out channel,
// in request order. The cfg channel writes the enable bit; it is always
// ready and is meant to be written while no request is in flight. A
// write that changes the enable bit frees every slot.
// One request is processed at a time. An acquire that is not refused sweeps
// all slots through the single read port of the owner memory, one slot per
// cycle, and a new request is taken only while the controller is idle.
// Release, check and refused requests skip the sweep; a check reads its own slot.
// Reset clears the enable bit and marks all slots free at once through
// per-slot valid bits; no clearing pass is needed.
// The response sits in an output register; if the receiver stalls, it waits
// there, and the next request is still taken but its response is held back
// until the output register is free.
module id_slot_claim_table import isct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  isct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  isct_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/isct_datapath.sv
// datapath of the slot claim table: owner memory, valid bits, compare and result register
`timescale 1ns / 1ps

module isct_datapath import isct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  req_t       in_data_i,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output rsp_t       out_data_o
);

  logic [63:0]           mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_q, vld_d;
  logic                  enabled_q;
  req_t                  req_q;

  logic [63:0]       rdata_q;
  logic              rvld_q;
  logic [SLOT_W-1:0] cmp_idx_q;
  logic [SLOT_W-1:0] rd_addr;

  logic              hit_q, free_q;
  logic [SLOT_W-1:0] hit_idx_q, free_idx_q;

  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, res;
  logic              do_claim, do_free;
  logic              slot_in_range;
  logic              entry_match, entry_free;

  assign slot_in_range = 32'(req_q.slot) < SLOT_COUNT;
  assign rd_addr       = cmd_i.rd_sel_slot ? SLOT_W'(req_q.slot) : cmd_i.rd_addr;

  assign status_o.need_scan = (req_q.kind == KIND_ACQUIRE) && enabled_q &&
                              (req_q.owner_id != FREE_MARK);
  assign status_o.need_read = (req_q.kind == KIND_CHECK) && enabled_q && slot_in_range;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
  end

  // owner memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (do_claim) begin
      mem[free_idx_q] <= req_q.owner_id;
    end
    if (cmd_i.rd_en) begin
      rdata_q   <= mem[rd_addr];
      rvld_q    <= vld_q[rd_addr];
      cmp_idx_q <= rd_addr;
    end
  end

  assign entry_match = rvld_q && (rdata_q == req_q.owner_id);
  assign entry_free  = !rvld_q;

  always_comb begin
    vld_d = vld_q;
    if (cfg_we_i && (cfg_data_i != enabled_q)) begin
      vld_d = '0;
    end else if (do_claim) begin
      vld_d[free_idx_q] = 1'b1;
    end else if (do_free) begin
      vld_d[SLOT_W'(req_q.slot)] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      enabled_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      hit_idx_q   <= '0;
      free_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        enabled_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (cmd_i.cmp_en) begin
        if (entry_match && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= cmp_idx_q;
        end
        if (entry_free && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= cmp_idx_q;
        end
      end
    end
  end

  always_comb begin
    res      = '{status: ST_NOT_HELD, slot_index: 3'd0};
    do_claim = 1'b0;
    do_free  = 1'b0;
    case (req_q.kind)
      KIND_ACQUIRE: begin
        if (!enabled_q) begin
          res.status = ST_NOT_ENABLED;
        end else if (req_q.owner_id == FREE_MARK) begin
          res.status = ST_FULL;
        end else if (hit_q) begin
          res.status     = ST_ALREADY;
          res.slot_index = 3'(hit_idx_q);
        end else if (free_q) begin
          res.status     = ST_ACQUIRED;
          res.slot_index = 3'(free_idx_q);
          do_claim       = cmd_i.commit;
        end else begin
          res.status = ST_FULL;
        end
      end
      KIND_RELEASE: begin
        res.status = ST_RELEASED;
        do_free    = cmd_i.commit && slot_in_range;
      end
      KIND_CHECK: begin
        if (!enabled_q) begin
          res.status = ST_NOT_ENABLED;
        end else if (hit_q && slot_in_range && (req_q.owner_id != FREE_MARK)) begin
          res.status     = ST_STILL;
          res.slot_index = req_q.slot;
        end else begin
          res.status = ST_NOT_HELD;
        end
      end
      default: begin
        res.status = ST_NOT_HELD;
      end
    endcase
  end

  assign out_valid_d = cmd_i.commit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/isct_ctrl.sv
// controller of the slot claim table: request sequencing and slot sweep
`timescale 1ns / 1ps

module isct_ctrl import isct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_LAST  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic [SLOT_W-1:0] LAST_ADDR = SLOT_W'(SLOT_COUNT - 1);

  logic [2:0]        state_q, state_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (status_i.need_scan) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = '0;
          cnt_d         = SLOT_W'(1);
          state_d       = (SLOT_COUNT > 1) ? S_SCAN : S_LAST;
        end else if (status_i.need_read) begin
          cmd_o.rd_en       = 1'b1;
          cmd_o.rd_sel_slot = 1'b1;
          state_d           = S_LAST;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SCAN: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = cnt_q;
        cmd_o.cmp_en  = 1'b1;
        cnt_d         = cnt_q + SLOT_W'(1);
        if (cnt_q == LAST_ADDR) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        cmd_o.cmp_en = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> test/testbench.sv
// self-checking testbench for the slot claim table with a scoreboard class
`timescale 1ns / 1ps

module testbench;
  import isct_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int POOL_SIZE   = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 30;
  localparam int IDLE_LIMIT  = 4000;

  class claim_scoreboard;
    logic [63:0] owner_tbl [SLOT_COUNT];
    bit          enabled;
    rsp_t        pending_rsp [$];
    int          errors;
    int          n_checked;
    int          status_hits [8];

    function new();
      free_all();
      enabled = 1'b0;
      errors = 0;
      n_checked = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void free_all();
      foreach (owner_tbl[i]) owner_tbl[i] = FREE_MARK;
    endfunction

    function void write_enable(bit v);
      if (v != enabled) free_all();
      enabled = v;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int   found;
      int   free_at;
      e.status = ST_NOT_HELD;
      e.slot_index = '0;
      case (r.kind)
        KIND_ACQUIRE: begin
          if (!enabled) begin
            e.status = ST_NOT_ENABLED;
          end else if (r.owner_id == FREE_MARK) begin
            e.status = ST_FULL;
          end else begin
            found = -1;
            free_at = -1;
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (found < 0 && owner_tbl[i] == r.owner_id) found = i;
              if (free_at < 0 && owner_tbl[i] == FREE_MARK) free_at = i;
            end
            if (found >= 0) begin
              e.status = ST_ALREADY;
              e.slot_index = 3'(found);
            end else if (free_at >= 0) begin
              owner_tbl[free_at] = r.owner_id;
              e.status = ST_ACQUIRED;
              e.slot_index = 3'(free_at);
            end else begin
              e.status = ST_FULL;
            end
          end
        end
        KIND_RELEASE: begin
          if (int'(r.slot) < SLOT_COUNT) owner_tbl[r.slot] = FREE_MARK;
          e.status = ST_RELEASED;
        end
        KIND_CHECK: begin
          if (!enabled) begin
            e.status = ST_NOT_ENABLED;
          end else if (int'(r.slot) < SLOT_COUNT && r.owner_id != FREE_MARK &&
                       owner_tbl[r.slot] == r.owner_id) begin
            e.status = ST_STILL;
            e.slot_index = r.slot;
          end
        end
        default: e.status = ST_NOT_HELD;
      endcase
      pending_rsp.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      n_checked++;
      status_hits[got.status]++;
      if (pending_rsp.size() == 0) begin
        $error("response with nothing outstanding: status %0d slot_index %0d",
               got.status, got.slot_index);
        errors++;
        return;
      end
      e = pending_rsp.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.slot_index !== e.slot_index) begin
        $error("slot_index: expected %0d, got %0d", e.slot_index, got.slot_index);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_data_i;

  claim_scoreboard sb;
  logic [63:0]     id_pool [POOL_SIZE];
  int              n_sent;
  int              n_cfg;
  bit              no_gaps;
  bit              hold_done;

  id_slot_claim_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic req_t mk(logic [1:0] kind, logic [63:0] id, logic [2:0] slot);
    req_t r;
    r.kind = kind;
    r.owner_id = id;
    r.slot = slot;
    return r;
  endfunction

  function automatic req_t random_req();
    int          roll;
    logic [2:0]  s;
    logic [63:0] id;
    roll = $urandom_range(99);
    s = 3'($urandom_range(7));
    id = id_pool[$urandom_range(POOL_SIZE - 1)];
    if (roll < 40) return mk(KIND_ACQUIRE, id, s);
    if (roll < 62) return mk(KIND_RELEASE, id, s);
    if (roll < 92) begin
      if (sb.owner_tbl[s] != FREE_MARK && $urandom_range(2) != 0) id = sb.owner_tbl[s];
      return mk(KIND_CHECK, id, s);
    end
    if (roll < 96) return mk(KIND_UNUSED, {$urandom, $urandom}, s);
    if (roll < 98) return mk(KIND_ACQUIRE, ($urandom_range(1) != 0) ? FREE_MARK :
                             {$urandom, $urandom}, s);
    return mk(KIND_CHECK, ($urandom_range(1) != 0) ? FREE_MARK : {$urandom, $urandom}, s);
  endfunction

  task automatic send_req(req_t r);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    n_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_enable(bit v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_enable(v);
    n_cfg++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic refresh_pool();
    foreach (id_pool[i]) id_pool[i] = {$urandom, $urandom};
  endtask

  // receiver: random ready pattern, one long hold-off once traffic is flowing
  initial begin
    int gap;
    int burst;
    out_ready_i = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!hold_done && n_sent >= 250) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        burst = ($urandom_range(7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
        out_ready_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_response(out_data_o);
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [63:0] id_a;
    logic [63:0] id_b;
    logic [63:0] id_c;
    bit          phase_en [6];
    int          phase_len [6];
    sb = new();
    n_sent = 0;
    n_cfg = 0;
    no_gaps = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    id_a = 64'h0;
    id_b = FREE_MARK - 64'd1;
    id_c = 64'h5555_aaaa_5555_aaaa;
    phase_en = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_len = '{200, 100, 40, 150, 20, 140};
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled after reset
    send_req(mk(KIND_ACQUIRE, id_a, 3'd0));
    send_req(mk(KIND_CHECK, id_a, 3'd0));
    send_req(mk(KIND_RELEASE, id_a, 3'd3));
    send_req(mk(KIND_UNUSED, id_b, 3'd5));
    drain();
    set_enable(1'b1);

    send_req(mk(KIND_ACQUIRE, id_a, 3'd7));
    send_req(mk(KIND_ACQUIRE, id_b, 3'd0));
    send_req(mk(KIND_ACQUIRE, id_a, 3'd2));
    send_req(mk(KIND_ACQUIRE, FREE_MARK, 3'd0));
    send_req(mk(KIND_CHECK, id_a, 3'd0));
    send_req(mk(KIND_CHECK, id_a, 3'd1));
    send_req(mk(KIND_CHECK, FREE_MARK, 3'd7));
    // fill the table, then one more gets full
    for (int i = 0; i < 7; i++) send_req(mk(KIND_ACQUIRE, {$urandom, $urandom}, 3'd0));
    send_req(mk(KIND_RELEASE, id_a, 3'd7));
    send_req(mk(KIND_ACQUIRE, id_c, 3'd0));
    send_req(mk(KIND_CHECK, id_c, 3'd7));
    send_req(mk(KIND_UNUSED, FREE_MARK, 3'd7));
    drain();
    set_enable(1'b1);
    send_req(mk(KIND_CHECK, id_b, 3'd1));
    drain();
    set_enable(1'b0);
    send_req(mk(KIND_RELEASE, id_b, 3'd1));
    send_req(mk(KIND_CHECK, id_b, 3'd1));
    drain();
    set_enable(1'b1);
    send_req(mk(KIND_CHECK, id_b, 3'd1));
    send_req(mk(KIND_RELEASE, id_b, 3'd0));

    for (int p = 0; p < 6; p++) begin
      drain();
      set_enable(phase_en[p]);
      refresh_pool();
      no_gaps = (p == 1);
      for (int i = 0; i < phase_len[p]; i++) send_req(random_req());
    end
    no_gaps = 1'b0;
    drain();

    if (sb.pending_rsp.size() != 0) begin
      $error("%0d responses never arrived", sb.pending_rsp.size());
      sb.errors++;
    end
    $display("covered %0d requests, %0d responses checked, %0d enable writes",
             n_sent, sb.n_checked, n_cfg);
    $display("statuses: acquired %0d already %0d full %0d still %0d not-held %0d",
             sb.status_hits[ST_ACQUIRED], sb.status_hits[ST_ALREADY],
             sb.status_hits[ST_FULL], sb.status_hits[ST_STILL],
             sb.status_hits[ST_NOT_HELD]);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
